// ----- rtl/spq_pkg.sv -----
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 8;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [DATA_W-1:0] item;
        logic [DATA_W-1:0] prio;
    } t_cell_data;

    // operation broadcast to every cell, already qualified by full/empty
    typedef struct packed {
        logic              ins;
        logic              pull;
        logic [DATA_W-1:0] item;
        logic [DATA_W-1:0] prio;
    } t_op;

endpackage

// ----- rtl/spq_cell.sv -----
module spq_cell
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  t_op        i_op,
    input  logic       i_valid,
    input  logic       i_prev_keep,
    input  t_cell_data i_prev,
    input  t_cell_data i_next,
    output logic       o_keep,
    output t_cell_data o_data
);

    t_cell_data r_data;
    t_cell_data n_data;

    // entry stays put on insert when it outranks or ties the new one
    assign o_keep = i_valid && (r_data.prio >= i_op.prio);

    always_comb begin
        n_data = r_data;
        if (i_op.pull) begin
            n_data = i_next;
        end else if (i_op.ins && !o_keep) begin
            if (i_prev_keep) begin
                n_data.item = i_op.item;
                n_data.prio = i_op.prio;
            end else begin
                n_data = i_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// sorted priority queue: a row of cells kept in descending priority order
// the result strobe o_done rises in the cycle after the transfer of a command
// throughput: one command per cycle, busy never rises
// every cell decides its next entry combinationally from its own compare and its neighbors
// reset clears the fill count and the result strobe, cell contents stay undefined
// the receiver cannot stall, each result is shown for exactly one cycle
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_mode,
    input  logic [DATA_W-1:0] i_item,
    input  logic [DATA_W-1:0] i_priority_req,
    output logic              o_done,
    output logic [DATA_W-1:0] o_pulled_item,
    output logic [DATA_W-1:0] o_pulled_priority,
    output logic              o_pulled_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [DATA_W-1:0] o_top_item,
    output logic [DATA_W-1:0] o_top_priority,
    output logic [OCC_W-1:0]  o_occupancy
);

    // control
    logic       accept;
    logic       full;
    logic       empty;
    t_op        op;

    // cell row signals
    logic       keep  [DEPTH];
    logic       valid [DEPTH];
    t_cell_data data  [DEPTH];

    // state and result registers
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    logic              r_done;
    logic [DATA_W-1:0] r_pulled_item;
    logic [DATA_W-1:0] r_pulled_prio;
    logic              r_pulled_valid;
    t_status           r_status;
    t_status           n_status;

    // the queue takes a command every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign full  = (r_fill == CNT_W'(DEPTH));
    assign empty = (r_fill == '0);

    // rejected commands never reach the cells
    assign op.ins  = accept && !i_mode && !full;
    assign op.pull = accept && i_mode && !empty;
    assign op.item = i_item;
    assign op.prio = i_priority_req;

    // cell row: cell 0 is the head, each one talks only to its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_data prev_data;
        t_cell_data next_data;
        logic       prev_keep;

        assign valid[g] = (CNT_W'(g) < r_fill);

        if (g == 0) begin : g_head
            assign prev_keep = 1'b1;
            assign prev_data = data[g];
        end else begin : g_body
            assign prev_keep = keep[g-1];
            assign prev_data = data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign next_data = data[g];
        end else begin : g_inner
            assign next_data = data[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (op),
            .i_valid     (valid[g]),
            .i_prev_keep (prev_keep),
            .i_prev      (prev_data),
            .i_next      (next_data),
            .o_keep      (keep[g]),
            .o_data      (data[g])
        );
    end

    // fill count and status
    always_comb begin
        n_fill   = r_fill;
        n_status = ST_DONE;
        if (op.ins) begin
            n_fill = r_fill + CNT_W'(1);
        end else if (op.pull) begin
            n_fill = r_fill - CNT_W'(1);
        end
        if (accept && !i_mode && full) begin
            n_status = ST_FULL;
        end else if (accept && i_mode && empty) begin
            n_status = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_done <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_done <= accept;
        end
    end

    // result payload, the head leaves through cell 0
    always_ff @(posedge i_clk) begin
        r_status       <= n_status;
        r_pulled_valid <= op.pull;
        r_pulled_item  <= op.pull ? data[0].item : '0;
        r_pulled_prio  <= op.pull ? data[0].prio : '0;
    end

    assign o_done            = r_done;
    assign o_pulled_item     = r_pulled_item;
    assign o_pulled_priority = r_pulled_prio;
    assign o_pulled_valid    = r_pulled_valid;
    assign o_status          = r_status;
    // cells updated on the same edge as the result registers
    assign o_top_item        = empty ? '0 : data[0].item;
    assign o_top_priority    = empty ? '0 : data[0].prio;
    assign o_occupancy       = OCC_W'(r_fill);

    // each transfer gives exactly one strobe on the next cycle
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("missing result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_done)
        else $error("result strobe without a transfer");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // the pulled entry always outranks or ties the new head
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_pulled_valid) |-> (o_pulled_priority >= o_top_priority))
        else $error("pulled entry below new head");

endmodule
